>>> rtl/icf_pkg.sv
// Shared constants, control struct and helper function of the interpolated comb filter.
`timescale 1ns / 1ps

package icf_pkg;

    localparam int ICF_BUFFER_DEPTH = 65536;
    localparam int ICF_SAMPLE_WIDTH = 24;
    localparam int ICF_DELAY_W      = 24;
    localparam int ICF_GAIN_W       = 18;
    localparam int ICF_FRAC_W       = 8;
    localparam int ICF_ROUND_SHIFT  = 23;
    localparam int ICF_STEP_W       = 4;

    localparam logic [ICF_DELAY_W-1:0] ICF_ONE_SAMPLE   = 24'd256;
    localparam logic [ICF_DELAY_W-1:0] ICF_MAXDEL_RESET = 24'd122880;
    localparam longint ICF_DELAY_MAX = 64'sd16777215;

    // Steps of the shared multiply-accumulate sequence
    localparam logic [ICF_STEP_W-1:0] MS_HX0   = 4'd0;
    localparam logic [ICF_STEP_W-1:0] MS_HX1   = 4'd1;
    localparam logic [ICF_STEP_W-1:0] MS_DIR   = 4'd2;
    localparam logic [ICF_STEP_W-1:0] MS_FWD   = 4'd3;
    localparam logic [ICF_STEP_W-1:0] MS_HY0   = 4'd4;
    localparam logic [ICF_STEP_W-1:0] MS_HY1   = 4'd5;
    localparam logic [ICF_STEP_W-1:0] MS_SUMY  = 4'd6;
    localparam logic [ICF_STEP_W-1:0] MS_FBK   = 4'd7;
    localparam logic [ICF_STEP_W-1:0] MS_ACCFB = 4'd8;

    typedef struct packed {
        logic                  run;
        logic                  ld0;
        logic                  ld1;
        logic [ICF_STEP_W-1:0] step;
    } icf_mac_ctrl_t;

    // Number of conditional subtractions needed to fold a delay into the ring span
    function automatic int icf_mod_steps(longint span);
        int n;
        n = 1;
        for (int k = 0; k < ICF_DELAY_W + 1; k++)
        begin
            if ((span << k) <= ICF_DELAY_MAX)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/icf_history.sv
// Input and output sample ring buffers with one write and one registered read port.
`timescale 1ns / 1ps

module icf_history
    import icf_pkg::*;
#(
    parameter int BUFFER_DEPTH = ICF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = ICF_SAMPLE_WIDTH
)
(
    input  logic                            clk,
    input  logic                            x_we,
    input  logic                            y_we,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
    input  logic [SAMPLE_WIDTH-1:0]         x_wdata,
    input  logic [SAMPLE_WIDTH-1:0]         y_wdata,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
    output logic [SAMPLE_WIDTH-1:0]         x_rdata,
    output logic [SAMPLE_WIDTH-1:0]         y_rdata
);

    logic [SAMPLE_WIDTH-1:0] x_mem [BUFFER_DEPTH];
    logic [SAMPLE_WIDTH-1:0] y_mem [BUFFER_DEPTH];
    logic [SAMPLE_WIDTH-1:0] x_rdata_reg;
    logic [SAMPLE_WIDTH-1:0] y_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[wr_addr] <= x_wdata;
        end
        x_rdata_reg <= x_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[wr_addr] <= y_wdata;
        end
        y_rdata_reg <= y_mem[rd_addr];
    end

    assign x_rdata = x_rdata_reg;
    assign y_rdata = y_rdata_reg;

endmodule

>>> rtl/icf_addr_gen.sv
// Delay clamp, iterative fold into the ring span and interpolation address calculation.
`timescale 1ns / 1ps

module icf_addr_gen
    import icf_pkg::*;
#(
    parameter int BUFFER_DEPTH = ICF_BUFFER_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ICF_DELAY_W-1:0]          delay,
    input  logic [ICF_DELAY_W-1:0]          max_delay,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] wp,
    output logic                            done,
    output logic [$clog2(BUFFER_DEPTH)-1:0] rd_idx0,
    output logic [$clog2(BUFFER_DEPTH)-1:0] rd_idx1,
    output logic [ICF_FRAC_W-1:0]           frac
);

    localparam int     PTR_W     = $clog2(BUFFER_DEPTH);
    localparam int     CMP_W     = (PTR_W + ICF_FRAC_W + 1 > ICF_DELAY_W + 1) ?
                                   PTR_W + ICF_FRAC_W + 1 : ICF_DELAY_W + 1;
    localparam int     POS_W     = CMP_W + 1;
    localparam longint SPAN      = longint'(BUFFER_DEPTH) * 256;
    localparam int     MOD_STEPS = icf_mod_steps(SPAN);
    localparam int     CNT_W     = $clog2(MOD_STEPS + 1);

    localparam logic [CMP_W-1:0] SPAN_C   = CMP_W'(SPAN);
    localparam logic [CMP_W-1:0] DIV_INIT = CMP_W'(SPAN << (MOD_STEPS - 1));
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(MOD_STEPS - 1);

    logic                   run_reg, run_next;
    logic                   pend_reg, pend_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CMP_W-1:0]       rem_reg;
    logic [CMP_W-1:0]       div_reg;
    logic [PTR_W-1:0]       idx0_reg;
    logic [PTR_W-1:0]       idx1_reg;
    logic [ICF_FRAC_W-1:0]  frac_reg;

    logic [ICF_DELAY_W-1:0] d_lim;
    logic [ICF_DELAY_W-1:0] d_cl;
    logic [POS_W-1:0]       pos_sum;
    logic [POS_W-1:0]       pos_wrap;
    logic [PTR_W-1:0]       idx0;

    // Clamp to the maximum first, then raise to one sample
    always_comb
    begin
        d_lim = (delay > max_delay) ? max_delay : delay;
        d_cl  = (d_lim < ICF_ONE_SAMPLE) ? ICF_ONE_SAMPLE : d_lim;
    end

    // Read position behind the write pointer, one compare and subtract to wrap
    always_comb
    begin
        pos_sum  = {{(POS_W - PTR_W - ICF_FRAC_W){1'b0}}, wp, {ICF_FRAC_W{1'b0}}}
                 + {1'b0, SPAN_C} - {1'b0, rem_reg};
        pos_wrap = (pos_sum >= {1'b0, SPAN_C}) ? pos_sum - {1'b0, SPAN_C} : pos_sum;
        idx0     = pos_wrap[PTR_W+ICF_FRAC_W-1:ICF_FRAC_W];
    end

    always_comb
    begin
        run_next  = run_reg;
        pend_next = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_INIT;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                pend_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        if (pend_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(CMP_W - ICF_DELAY_W){1'b0}}, d_cl};
            div_reg <= DIV_INIT;
        end
        else if (run_reg)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg <= div_reg >> 1;
        end
        if (pend_reg)
        begin
            idx0_reg <= idx0;
            idx1_reg <= (idx0 == PTR_LAST) ? '0 : idx0 + 1'b1;
            frac_reg <= pos_wrap[ICF_FRAC_W-1:0];
        end
    end

    assign done    = done_reg;
    assign rd_idx0 = idx0_reg;
    assign rd_idx1 = idx1_reg;
    assign frac    = frac_reg;

endmodule

>>> rtl/icf_mac.sv
// Shared multiplier with interpolation and output accumulators, rounding and saturation.
`timescale 1ns / 1ps

module icf_mac
    import icf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = ICF_SAMPLE_WIDTH
)
(
    input  logic                         clk,
    input  icf_mac_ctrl_t                ctrl,
    input  logic [SAMPLE_WIDTH-1:0]      x_rdata,
    input  logic [SAMPLE_WIDTH-1:0]      y_rdata,
    input  logic [ICF_FRAC_W-1:0]        frac,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [ICF_GAIN_W-1:0] direct_gain,
    input  logic signed [ICF_GAIN_W-1:0] forward_gain,
    input  logic signed [ICF_GAIN_W-1:0] feedback_gain,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int AW    = SAMPLE_WIDTH + ICF_FRAC_W;
    localparam int PW    = AW + ICF_GAIN_W;
    localparam int ACC_W = PW + 2;
    localparam int WPAD  = ICF_GAIN_W - ICF_FRAC_W - 1;

    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) <<< (ICF_ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SAMPLE_WIDTH - 1));

    logic signed [SAMPLE_WIDTH-1:0] hx0_reg, hx1_reg, hy0_reg, hy1_reg;
    logic signed [PW-1:0]           mul_reg;
    logic signed [AW-1:0]           ip_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    logic        [ICF_FRAC_W:0]     w0;
    logic signed [AW-1:0]           opa;
    logic signed [ICF_GAIN_W-1:0]   opb;
    logic signed [ACC_W-1:0]        mul_ext;
    logic signed [ACC_W-1:0]        shifted;

    always_comb
    begin
        w0 = 9'd256 - {1'b0, frac};
        case (ctrl.step)
            MS_HX0:
            begin
                opa = {{ICF_FRAC_W{hx0_reg[SAMPLE_WIDTH-1]}}, hx0_reg};
                opb = {{WPAD{1'b0}}, w0};
            end
            MS_HX1:
            begin
                opa = {{ICF_FRAC_W{hx1_reg[SAMPLE_WIDTH-1]}}, hx1_reg};
                opb = {{(WPAD + 1){1'b0}}, frac};
            end
            MS_DIR:
            begin
                opa = {{ICF_FRAC_W{sample[SAMPLE_WIDTH-1]}}, sample};
                opb = direct_gain;
            end
            MS_FWD:
            begin
                opa = ip_reg;
                opb = forward_gain;
            end
            MS_HY0:
            begin
                opa = {{ICF_FRAC_W{hy0_reg[SAMPLE_WIDTH-1]}}, hy0_reg};
                opb = {{WPAD{1'b0}}, w0};
            end
            MS_HY1:
            begin
                opa = {{ICF_FRAC_W{hy1_reg[SAMPLE_WIDTH-1]}}, hy1_reg};
                opb = {{(WPAD + 1){1'b0}}, frac};
            end
            MS_FBK:
            begin
                opa = ip_reg;
                opb = feedback_gain;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign mul_ext = {{(ACC_W - PW){mul_reg[PW-1]}}, mul_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.ld0)
        begin
            hx0_reg <= x_rdata;
            hy0_reg <= y_rdata;
        end
        if (ctrl.ld1)
        begin
            hx1_reg <= x_rdata;
            hy1_reg <= y_rdata;
        end
        mul_reg <= opa * opb;
        if (ctrl.run)
        begin
            case (ctrl.step)
                MS_HX1:   ip_reg  <= mul_reg[AW-1:0];
                MS_DIR:   ip_reg  <= ip_reg + mul_reg[AW-1:0];
                MS_FWD:   acc_reg <= (mul_ext <<< ICF_FRAC_W) + ROUND;
                MS_HY0:   acc_reg <= acc_reg + mul_ext;
                MS_HY1:   ip_reg  <= mul_reg[AW-1:0];
                MS_SUMY:  ip_reg  <= ip_reg + mul_reg[AW-1:0];
                MS_ACCFB: acc_reg <= acc_reg + mul_ext;
                default:  ;
            endcase
        end
    end

    // Floor shift then clip to the sample range
    always_comb
    begin
        shifted = acc_reg >>> ICF_ROUND_SHIFT;
        if (shifted > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            result = shifted[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

>>> rtl/interpolated_comb_filter.sv
// Top level of the interpolated comb filter: sequencer, pointers, channels and register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Carries
// ---------+-----------+-----------------------+----------------------------------------
// in       | to block  | in_valid / in_stall   | sample_in, delay, three gains
// out      | from blk  | out_valid / out_stall | sample_out
// cfg      | to block  | cfg_valid / cfg_ready | cfg_data = max_delay (Q16.8)
//
// A request is taken only while the block idles, and each one passes in order through the
// accepting cycle, MOD_STEPS conditional subtractions that fold the delay into the ring
// span, forming and handing over the read addresses, reading both histories (ST_RD0 to
// ST_RD2), nine multiply-accumulate steps on the one shared multiplier and a write-back.
// in_stall stays high after each acceptance until the write-back returns the block to idle.
// After reset, and after every max_delay write, a clearing pass zeroes every entry of both
// histories; no request is taken meanwhile, cfg writes still are.
// A finished result waits in the output register while the next request is taken;
// the block holds before its write-back only if that register is still stalled.

module interpolated_comb_filter
    import icf_pkg::*;
#(
    parameter int BUFFER_DEPTH = ICF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = ICF_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [ICF_DELAY_W-1:0]         delay,
    input  logic signed [ICF_GAIN_W-1:0]   direct_gain,
    input  logic signed [ICF_GAIN_W-1:0]   forward_gain,
    input  logic signed [ICF_GAIN_W-1:0]   feedback_gain,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ICF_DELAY_W-1:0]         cfg_data
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_RD0   = 3'd3;
    localparam logic [2:0] ST_RD1   = 3'd4;
    localparam logic [2:0] ST_RD2   = 3'd5;
    localparam logic [2:0] ST_MAC   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [ICF_STEP_W-1:0]  step_reg, step_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic [PTR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ICF_DELAY_W-1:0] max_delay_reg, max_delay_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [ICF_GAIN_W-1:0]   a_reg, b_reg, c_reg;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   done_fire;
    logic                   clearing;

    logic                   addr_done;
    logic [PTR_W-1:0]       rd_idx0, rd_idx1;
    logic [ICF_FRAC_W-1:0]  frac;

    logic                   x_we, y_we;
    logic [PTR_W-1:0]       wr_addr, rd_addr;
    logic [SAMPLE_WIDTH-1:0] x_wdata, y_wdata;
    logic [SAMPLE_WIDTH-1:0] x_rdata, y_rdata;

    icf_mac_ctrl_t              mac_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] mac_y;

    // Handshakes: a cfg write takes priority over a request in the same cycle
    assign clearing  = (state_reg == ST_CLEAR);
    assign cfg_ready = clearing || (state_reg == ST_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign in_accept = in_valid && !in_stall;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        wp_next        = wp_reg;
        clr_cnt_next   = clr_cnt_reg;
        max_delay_next = max_delay_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PTR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (addr_done)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                step_next  = MS_HX0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (step_reg == MS_ACCFB)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    out_valid_next = 1'b1;
                    wp_next        = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // A new maximum restarts the clearing pass and rewinds the pointer
        if (cfg_write)
        begin
            max_delay_next = cfg_data;
            clr_cnt_next   = '0;
            wp_next        = '0;
            state_next     = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= MS_HX0;
            wp_reg        <= '0;
            clr_cnt_reg   <= '0;
            max_delay_reg <= ICF_MAXDEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wp_reg        <= wp_next;
            clr_cnt_reg   <= clr_cnt_next;
            max_delay_reg <= max_delay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request fields for the whole calculation
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= sample_in;
            a_reg <= direct_gain;
            b_reg <= forward_gain;
            c_reg <= feedback_gain;
        end
        if (done_fire)
        begin
            sample_out_reg <= mac_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // History port: clearing sweep, x on acceptance, y on write-back
    assign x_we    = clearing || in_accept;
    assign y_we    = clearing || done_fire;
    assign wr_addr = clearing ? clr_cnt_reg : wp_reg;
    assign x_wdata = clearing ? '0 : sample_in;
    assign y_wdata = clearing ? '0 : mac_y;
    assign rd_addr = (state_reg == ST_RD0) ? rd_idx0 : rd_idx1;

    assign mac_ctrl.run  = (state_reg == ST_MAC);
    assign mac_ctrl.ld0  = (state_reg == ST_RD1);
    assign mac_ctrl.ld1  = (state_reg == ST_RD2);
    assign mac_ctrl.step = step_reg;

    icf_addr_gen #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .delay     (delay),
        .max_delay (max_delay_reg),
        .wp        (wp_reg),
        .done      (addr_done),
        .rd_idx0   (rd_idx0),
        .rd_idx1   (rd_idx1),
        .frac      (frac)
    );

    icf_history #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_history (
        .clk     (clk),
        .x_we    (x_we),
        .y_we    (y_we),
        .wr_addr (wr_addr),
        .x_wdata (x_wdata),
        .y_wdata (y_wdata),
        .rd_addr (rd_addr),
        .x_rdata (x_rdata),
        .y_rdata (y_rdata)
    );

    icf_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk           (clk),
        .ctrl          (mac_ctrl),
        .x_rdata       (x_rdata),
        .y_rdata       (y_rdata),
        .frac          (frac),
        .sample        (x_reg),
        .direct_gain   (a_reg),
        .forward_gain  (b_reg),
        .feedback_gain (c_reg),
        .result        (mac_y)
    );

    // An accepted request always starts the address phase
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_ADDR))
        else $error("accepted request did not enter the address phase");

    // The address unit reports completion only while the sequencer waits for it
    a_addr_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        addr_done |-> (state_reg == ST_ADDR))
        else $error("address result arrived outside the address phase");

    // The write pointer stays put while a calculation is in flight
    a_wp_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) && !cfg_valid |=> $stable(wp_reg))
        else $error("write pointer moved during calculation");

    // A result only appears from the write-back state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without write-back");

    // The clearing sweep runs with the pointer rewound
    a_clear_rewound: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (wp_reg == '0))
        else $error("write pointer not rewound during clearing");

endmodule

>>> test/comb_filter_checker.sv
// Predicts every output sample of the interpolated comb filter and compares it with the block.
`timescale 1ns / 1ps

module comb_filter_checker
    import icf_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [ICF_SAMPLE_WIDTH-1:0] sample_in,
    input  logic [ICF_DELAY_W-1:0]             delay,
    input  logic signed [ICF_GAIN_W-1:0]       direct_gain,
    input  logic signed [ICF_GAIN_W-1:0]       forward_gain,
    input  logic signed [ICF_GAIN_W-1:0]       feedback_gain,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [ICF_SAMPLE_WIDTH-1:0] sample_out,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ICF_DELAY_W-1:0]             cfg_data,
    output int                                 samples_owed,
    output int                                 mismatches
);

    localparam int     PTR_W      = $clog2(ICF_BUFFER_DEPTH);
    localparam int     POS_W      = PTR_W + ICF_FRAC_W;
    localparam longint SAT_HI     = (64'sd1 <<< (ICF_SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_LO     = -(64'sd1 <<< (ICF_SAMPLE_WIDTH - 1));
    localparam longint HALF_LSB   = 64'sd1 <<< (ICF_ROUND_SHIFT - 1);

    logic signed [ICF_SAMPLE_WIDTH-1:0] x_hist [ICF_BUFFER_DEPTH];
    logic signed [ICF_SAMPLE_WIDTH-1:0] y_hist [ICF_BUFFER_DEPTH];
    logic [PTR_W-1:0]                   wr_ptr;
    logic [ICF_DELAY_W-1:0]             delay_limit;
    logic signed [ICF_SAMPLE_WIDTH-1:0] expected_samples [$];

    task automatic clear_histories();
        for (int k = 0; k < ICF_BUFFER_DEPTH; k++)
        begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
        wr_ptr = '0;
    endtask

    // Linear interpolation between two neighbouring entries, in 2^-8 sample LSB
    function automatic longint delayed_tap(input bit from_output, input logic [PTR_W-1:0] idx0,
                                           input longint frac);
        logic [PTR_W-1:0] idx1;
        longint           lower;
        longint           upper;
        idx1 = idx0 + 1'b1;
        if (from_output)
        begin
            lower = longint'(y_hist[idx0]);
            upper = longint'(y_hist[idx1]);
        end
        else
        begin
            lower = longint'(x_hist[idx0]);
            upper = longint'(x_hist[idx1]);
        end
        return lower * (longint'(ICF_ONE_SAMPLE) - frac) + upper * frac;
    endfunction

    // One filter step: store x, read both delayed taps, round, saturate, store y
    function automatic logic signed [ICF_SAMPLE_WIDTH-1:0] filter_step(
        input logic signed [ICF_SAMPLE_WIDTH-1:0] x,
        input logic [ICF_DELAY_W-1:0]             d_req,
        input logic signed [ICF_GAIN_W-1:0]       a,
        input logic signed [ICF_GAIN_W-1:0]       b,
        input logic signed [ICF_GAIN_W-1:0]       c
    );
        logic [ICF_DELAY_W-1:0] d;
        logic [POS_W-1:0]       pos;
        longint                 frac;
        longint                 dx;
        longint                 dy;
        longint                 acc;
        longint                 y;
        x_hist[wr_ptr] = x;
        d = d_req;
        if (d > delay_limit)
            d = delay_limit;
        if (d < ICF_ONE_SAMPLE)
            d = ICF_ONE_SAMPLE;
        pos  = {wr_ptr, {ICF_FRAC_W{1'b0}}} - d;
        frac = longint'(pos[ICF_FRAC_W-1:0]);
        dx   = delayed_tap(1'b0, pos[POS_W-1:ICF_FRAC_W], frac);
        dy   = delayed_tap(1'b1, pos[POS_W-1:ICF_FRAC_W], frac);
        acc  = longint'(a) * longint'(x) * 256 + longint'(b) * dx + longint'(c) * dy + HALF_LSB;
        y    = acc >>> ICF_ROUND_SHIFT;
        if (y > SAT_HI)
            y = SAT_HI;
        if (y < SAT_LO)
            y = SAT_LO;
        y_hist[wr_ptr] = y[ICF_SAMPLE_WIDTH-1:0];
        wr_ptr = wr_ptr + 1'b1;
        return y[ICF_SAMPLE_WIDTH-1:0];
    endfunction

    always @(posedge clk)
    begin : watch
        logic signed [ICF_SAMPLE_WIDTH-1:0] want;
        if (!rst_n)
        begin
            delay_limit = ICF_MAXDEL_RESET;
            clear_histories();
            expected_samples.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: sample_out expected nothing, got %0d", $time, sample_out);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        mismatches++;
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want, sample_out);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                delay_limit = cfg_data;
                clear_histories();
            end
            if (in_valid && !in_stall)
                expected_samples.push_back(filter_step(sample_in, delay, direct_gain,
                                                       forward_gain, feedback_gain));
        end
        samples_owed <= expected_samples.size();
    end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the interpolated comb filter, checked by comb_filter_checker.
`timescale 1ns / 1ps

module testbench;
    import icf_pkg::*;

    // Random requests per max_delay setting; six settings give about 1800 in all
    localparam int RANDOM_PER_PHASE = 300;
    // Requests between redraws of the idling modes, so that busy and quiet stretches alternate
    localparam int MODE_STRETCH     = 50;
    // Cycles to hold after the last result
    localparam int SETTLE_CYCLES    = 40;
    // Slowest run: six clearing passes plus ~1800 requests, roughly 4.5 ms;
    // allow several times that
    localparam int RUN_LIMIT_NS     = 25_000_000;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [ICF_SAMPLE_WIDTH-1:0] sample_in;
    logic [ICF_DELAY_W-1:0]             delay;
    logic signed [ICF_GAIN_W-1:0]       direct_gain;
    logic signed [ICF_GAIN_W-1:0]       forward_gain;
    logic signed [ICF_GAIN_W-1:0]       feedback_gain;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [ICF_SAMPLE_WIDTH-1:0] sample_out;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ICF_DELAY_W-1:0]             cfg_data;

    int                     samples_owed;
    int                     mismatches;
    bit                     idle_in;
    bit                     idle_out;
    logic [ICF_DELAY_W-1:0] limit_now;
    int                     phase_requests;

    interpolated_comb_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_in     (sample_in),
        .delay         (delay),
        .direct_gain   (direct_gain),
        .forward_gain  (forward_gain),
        .feedback_gain (feedback_gain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // The checker sits beside the block, sees the same wires and keeps the failure count
    comb_filter_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_in     (sample_in),
        .delay         (delay),
        .direct_gain   (direct_gain),
        .forward_gain  (forward_gain),
        .feedback_gain (feedback_gain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .samples_owed  (samples_owed),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Result side: while idling is on, hold out_stall high for a random length before each result.
    // Stalls start before a result appears too, so they land on every phase of the work.
    initial
    begin : result_sink
        int stall_cycles;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall_cycles = idle_out ? $urandom_range(0, 3) : 0;
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            // out_stall is low from here, so the edge that sees out_valid takes the result
            do @(posedge clk); while (!out_valid);
        end
    end

    // Present one request and hold it until the block takes it.
    // in_valid is left high on return so that back-to-back requests need no extra edge.
    task automatic send_request(input logic signed [ICF_SAMPLE_WIDTH-1:0] x,
                                input logic [ICF_DELAY_W-1:0]             d,
                                input logic signed [ICF_GAIN_W-1:0]       a,
                                input logic signed [ICF_GAIN_W-1:0]       b,
                                input logic signed [ICF_GAIN_W-1:0]       c);
        int gap;
        gap = idle_in ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample_in     <= x;
        delay         <= d;
        direct_gain   <= a;
        forward_gain  <= b;
        feedback_gain <= c;
        // Sampled just after the edge, in_stall still shows the value the edge saw
        do @(posedge clk); while (in_stall);
        phase_requests++;
    endtask

    // Drop the request valid and hold until every predicted sample has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (samples_owed != 0);
    endtask

    // Mostly moderate gains (within +-0.75) so the feedback stays audible, now and
    // then a draw over the whole Q3.15 range to hit every bit and force saturation
    function automatic logic signed [ICF_GAIN_W-1:0] draw_gain();
        if ($urandom_range(0, 4) == 0)
            return ICF_GAIN_W'($urandom());
        return ICF_GAIN_W'($urandom_range(0, 49152) - 24576);
    endfunction

    task automatic random_phase();
        logic signed [ICF_SAMPLE_WIDTH-1:0] x;
        logic [ICF_DELAY_W-1:0]             d;
        int                                 pick;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            if (n % MODE_STRETCH == 0)
            begin
                idle_in  = ($urandom_range(0, 3) != 0);
                idle_out = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) == 0)
                x = ICF_SAMPLE_WIDTH'($urandom_range(0, 8192) - 4096);
            else
                x = ICF_SAMPLE_WIDTH'($urandom());
            // Most delays reach back into history written in this phase; the rest
            // probe the clamps: below one sample, anywhere, and around max_delay
            pick = $urandom_range(0, 99);
            if (pick < 10)
                d = ICF_DELAY_W'($urandom_range(0, 255));
            else if (pick < 25)
                d = ICF_DELAY_W'($urandom());
            else if (pick < 65)
                d = ICF_DELAY_W'($urandom_range(0, (phase_requests + 2) * 256));
            else if (pick < 80)
                d = ICF_DELAY_W'(limit_now + $urandom_range(0, 512) - 256);
            else
                d = ICF_DELAY_W'($urandom_range(256, 2047));
            send_request(x, d, draw_gain(), draw_gain(), draw_gain());
        end
    endtask

    // Write max_delay with the block idle, then run a random phase on fresh histories
    task automatic retune(input logic [ICF_DELAY_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now      = value;
        phase_requests = 0;
        random_phase();
    endtask

    initial
    begin
        // Initialise every input before the first edge and hold reset low until rst_n is raised
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        sample_in     <= '0;
        delay         <= '0;
        direct_gain   <= '0;
        forward_gain  <= '0;
        feedback_gain <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        idle_in        = 1'b1;
        idle_out       = 1'b1;
        limit_now      = ICF_MAXDEL_RESET;
        phase_requests = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests on the reset setting (480 samples); the write pointer starts at 0.
        // Largest input times the largest direct gain: saturate upwards
        send_request(24'sh7FFFFF, 24'd0, 18'sh1FFFF, 18'sd0, 18'sd0);
        // Pointer 1 with a delay between one and two samples: the lower tap sits at the
        // ring top and its partner wraps round to entry 0
        send_request(24'sh800000, 24'd300, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
        // Exactly one sample: the partner is the entry just written; most negative gains
        send_request(24'sh000000, 24'd256, 18'sh20000, 18'sh20000, 18'sh20000);
        // Below one sample: raised to one sample
        send_request(24'sd1, 24'd255, 18'sd32768, -18'sd32768, 18'sd16384);
        // All-ones delay, far beyond max_delay: clamp
        send_request(-24'sd1, 24'hFFFFFF, 18'sd1, 18'sd1, 18'sd1);
        // Exactly at max_delay, then one step above it
        send_request(24'sh400000, 24'd122880, 18'sd32768, 18'sd32768, -18'sd32768);
        send_request(-24'sh400000, 24'd122881, -18'sd32768, 18'sd16384, 18'sd16384);
        // Rounding: +0.5 LSB rounds up to 1, -0.5 LSB rounds up to 0
        send_request(24'sd16384, 24'd511, 18'sd1, 18'sd0, 18'sd0);
        send_request(-24'sd16384, 24'd640, 18'sd1, 18'sd0, 18'sd0);
        // Most negative input and gain: saturate upwards; then largest input, negative gain
        send_request(24'sh800000, 24'd384, 18'sh20000, 18'sd0, 18'sd0);
        send_request(24'sh7FFFFF, 24'd1000, 18'sh20000, 18'sd0, 18'sd0);
        // Fractional delays through the feedforward and feedback paths, then a zero delay through feedback alone
        send_request(24'sd123456, 24'h000180, 18'sd0, 18'sd32767, 18'sd32767);
        send_request(-24'sd654321, 24'd2637, 18'sd0, -18'sd32768, 18'sd32767);
        send_request(24'sd555555, 24'd0, 18'sd0, 18'sd0, 18'sh1FFFF);
        // Alternating bit patterns on every field
        send_request(24'shAAAAAA, 24'h555555, 18'sh2AAAA, 18'sh15555, 18'sh2AAAA);
        send_request(24'sh555555, 24'hAAAAAA, 18'sh15555, 18'sh2AAAA, 18'sh15555);
        random_phase();

        // Walk max_delay through its extremes: one sample, the top of the range, zero,
        // all ones, and a short fractional delay
        retune(24'd256);
        retune(24'd16776960);
        retune(24'd0);
        retune(24'hFFFFFF);
        retune(24'd1000);

        // Let the pipeline empty, then hold a little longer for any stray result
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/icf_pkg.sv
rtl/icf_history.sv
rtl/icf_addr_gen.sv
rtl/icf_mac.sv
rtl/interpolated_comb_filter.sv
test/comb_filter_checker.sv
test/testbench.sv
